// ----- src/arp_pkg.sv -----
`timescale 1ns / 1ps

package arp_pkg;

    // relocation type codes, standard arm elf numbering
    localparam logic [7:0] RC_NONE     = 8'd0;
    localparam logic [7:0] RC_ABS32    = 8'd2;
    localparam logic [7:0] RC_REL32    = 8'd3;
    localparam logic [7:0] RC_THM_CALL = 8'd10;
    localparam logic [7:0] RC_CALL     = 8'd28;
    localparam logic [7:0] RC_JUMP24   = 8'd29;
    localparam logic [7:0] RC_TARGET1  = 8'd38;
    localparam logic [7:0] RC_V4BX     = 8'd40;
    localparam logic [7:0] RC_TARGET2  = 8'd41;
    localparam logic [7:0] RC_PREL31   = 8'd42;
    localparam logic [7:0] RC_MOVW     = 8'd43;
    localparam logic [7:0] RC_MOVT     = 8'd44;
    localparam logic [7:0] RC_THM_MOVW = 8'd47;
    localparam logic [7:0] RC_THM_MOVT = 8'd48;

    localparam logic [31:0] V4BX_KEEP_MASK = 32'hf000000f;
    localparam logic [31:0] V4BX_MOV_PC_LR = 32'h01a0f000;

    typedef enum logic [2:0] {
        ST_WRITE   = 3'd0,
        ST_NOOP    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_RANGE   = 3'd3,
        ST_BEYOND  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  reloc_code;
        logic [31:0] addend;
        logic [31:0] sym_addr;
        logic [31:0] seg_addr;
        logic [31:0] patch_offset;
        logic [31:0] seg_file_size;
        logic [31:0] old_word;
    } t_reloc;

    typedef struct packed {
        logic [31:0] patch_address;
        logic [31:0] new_word;
        t_status     status;
    } t_patch;

endpackage

// ----- src/arp_patch_calc.sv -----
`timescale 1ns / 1ps

module arp_patch_calc (
    input  arp_pkg::t_reloc i_reloc,
    output arp_pkg::t_patch o_patch
);

    logic [31:0]       place;
    logic [31:0]       absv;
    logic [31:0]       rel;
    logic [15:0]       hi;
    logic [15:0]       lo;
    logic [15:0]       imm;
    logic [15:0]       nh;
    logic [15:0]       nl;
    logic              sg;
    logic              j1;
    logic              j2;
    logic              thm_ok;
    logic              arm_ok;
    logic              beyond;
    logic [31:0]       val;
    arp_pkg::t_status  st;

    assign place = i_reloc.seg_addr + i_reloc.patch_offset;
    assign absv  = i_reloc.sym_addr + i_reloc.addend;
    assign rel   = absv - place;
    assign hi    = i_reloc.old_word[15:0];
    assign lo    = i_reloc.old_word[31:16];

    // signed reach: +-(2^24 - 1) thumb, +-(2^25 - 1) arm
    assign thm_ok = (rel[31:24] == 8'h00) || ((rel[31:24] == 8'hff) && (rel[23:0] != 24'd0));
    assign arm_ok = (rel[31:25] == 7'h00) || ((rel[31:25] == 7'h7f) && (rel[24:0] != 25'd0));

    // 33-bit compare, no wrap on offset + 4
    assign beyond = ({1'b0, i_reloc.patch_offset} + 33'd4) > {1'b0, i_reloc.seg_file_size};

    assign sg = rel[24];
    assign j1 = sg ^ ~rel[23];
    assign j2 = sg ^ ~rel[22];

    always_comb begin
        if (i_reloc.reloc_code == arp_pkg::RC_MOVT ||
            i_reloc.reloc_code == arp_pkg::RC_THM_MOVT) begin
            imm = absv[31:16];
        end else begin
            imm = absv[15:0];
        end
    end

    always_comb begin
        val = i_reloc.old_word;
        st  = arp_pkg::ST_WRITE;
        nh  = hi;
        nl  = lo;
        case (i_reloc.reloc_code)
            arp_pkg::RC_NONE: begin
                st = arp_pkg::ST_NOOP;
            end
            arp_pkg::RC_V4BX: begin
                val = (i_reloc.old_word & arp_pkg::V4BX_KEEP_MASK) | arp_pkg::V4BX_MOV_PC_LR;
            end
            arp_pkg::RC_ABS32, arp_pkg::RC_TARGET1: begin
                val = absv;
            end
            arp_pkg::RC_REL32, arp_pkg::RC_TARGET2: begin
                val = rel;
            end
            arp_pkg::RC_THM_CALL: begin
                if (!thm_ok) begin
                    st = arp_pkg::ST_RANGE;
                end else begin
                    nh  = {hi[15:11], sg, rel[21:12]};
                    nl  = {lo[15:14], j1, lo[12], j2, rel[11:1]};
                    val = {nl, nh};
                end
            end
            arp_pkg::RC_CALL, arp_pkg::RC_JUMP24: begin
                if (!arm_ok) begin
                    st = arp_pkg::ST_RANGE;
                end else begin
                    val = {i_reloc.old_word[31:24], rel[25:2]};
                end
            end
            arp_pkg::RC_PREL31: begin
                val = {i_reloc.old_word[31], rel[30:0]};
            end
            arp_pkg::RC_MOVW, arp_pkg::RC_MOVT: begin
                val = {i_reloc.old_word[31:20], imm[15:12], i_reloc.old_word[15:12], imm[11:0]};
            end
            arp_pkg::RC_THM_MOVW, arp_pkg::RC_THM_MOVT: begin
                nh  = {hi[15:11], imm[11], hi[9:4], imm[15:12]};
                nl  = {lo[15], imm[10:8], lo[11:8], imm[7:0]};
                val = {nl, nh};
            end
            default: begin
                st = arp_pkg::ST_UNKNOWN;
            end
        endcase
        if (st == arp_pkg::ST_WRITE && beyond) begin
            st = arp_pkg::ST_BEYOND;
        end
    end

    assign o_patch.patch_address = place;
    assign o_patch.new_word      = (st == arp_pkg::ST_WRITE) ? val : i_reloc.old_word;
    assign o_patch.status        = st;

endmodule

// ----- src/arm_relocation_patcher_top.sv -----
`timescale 1ns / 1ps

// arm relocation patcher: takes one decoded arm elf relocation per item and
// returns the patch address, the patched word and a status. an item is taken
// at every edge where start is high; busy is always low, so items may stream
// one per cycle with no gaps. each result passes through the input register and
// the result register, then appears on o_patch_address / o_new_word / o_status
// for exactly one cycle with o_done high; there is no way to stall it, so the
// receiver must take it then. these two registers sit on either side of one
// combinational pass (two chained 32-bit adds, range and bounds compares, field
// muxing). status: 0 write, 1 no-op, 2 unknown code, 3 branch out of range, 4
// patch beyond segment; on any status other than write, o_new_word repeats the
// old word unchanged so the write can simply be suppressed.

module arm_relocation_patcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_reloc_code,
    input  logic [31:0] i_addend,
    input  logic [31:0] i_sym_addr,
    input  logic [31:0] i_seg_addr,
    input  logic [31:0] i_patch_offset,
    input  logic [31:0] i_seg_file_size,
    input  logic [31:0] i_old_word,
    output logic        o_done,
    output logic [31:0] o_patch_address,
    output logic [31:0] o_new_word,
    output logic [2:0]  o_status
);

    // input stage
    logic            r_in_valid;
    arp_pkg::t_reloc r_reloc;

    // result stage
    logic            r_out_valid;
    arp_pkg::t_patch r_patch;
    arp_pkg::t_patch n_patch;

    // no internal backpressure: every cycle can take a new item
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_reloc.reloc_code    <= i_reloc_code;
            r_reloc.addend        <= i_addend;
            r_reloc.sym_addr      <= i_sym_addr;
            r_reloc.seg_addr      <= i_seg_addr;
            r_reloc.patch_offset  <= i_patch_offset;
            r_reloc.seg_file_size <= i_seg_file_size;
            r_reloc.old_word      <= i_old_word;
        end
        if (r_in_valid) begin
            r_patch <= n_patch;
        end
    end

    // all per-relocation math in one pass
    arp_patch_calc u_calc (
        .i_reloc (r_reloc),
        .o_patch (n_patch)
    );

    assign o_done          = r_out_valid;
    assign o_patch_address = r_patch.patch_address;
    assign o_new_word      = r_patch.new_word;
    assign o_status        = r_patch.status;

endmodule

// ----- src/arp_checker.sv -----
`timescale 1ns / 1ps

module arp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] i_seg_addr,
    input logic [31:0] i_patch_offset,
    input logic [31:0] i_old_word,
    input logic        o_done,
    input logic [31:0] o_patch_address,
    input logic [31:0] o_new_word,
    input logic [2:0]  o_status
);

    // block never pushes back
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every taken item yields a result with o_done high
    a_item_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result missing for taken item");

    // no result without a taken item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start, 2) && $past(i_rst_n, 2)))
        else $error("result without item");

    // address is always base plus offset of the item
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_patch_address == ($past(i_seg_addr, 2) + $past(i_patch_offset, 2))))
        else $error("patch address mismatch");

    // suppressed writes keep the old word
    a_keep_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != arp_pkg::ST_WRITE)) |-> (o_new_word == $past(i_old_word, 2)))
        else $error("old word not kept on suppressed write");

endmodule

bind arm_relocation_patcher_top arp_checker u_arp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_seg_addr      (i_seg_addr),
    .i_patch_offset  (i_patch_offset),
    .i_old_word      (i_old_word),
    .o_done          (o_done),
    .o_patch_address (o_patch_address),
    .o_new_word      (o_new_word),
    .o_status        (o_status)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import arp_pkg::*;

    // codes outside the handled set
    localparam logic [7:0] RC_UNUSED_TOP = 8'd255;

    // branch reach: thumb +-16 MiB, arm +-32 MiB
    localparam logic [31:0] THUMB_REACH = 32'h0100_0000;
    localparam logic [31:0] ARM_REACH   = 32'h0200_0000;

    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_FIRST   = 300;   // stretch with no sender gaps
    localparam int CALM_LAST    = 520;
    localparam int DRAIN_AT     = 600;   // sender holds off until all results are in
    localparam int STALL_LIMIT  = 400;   // cycles with no item and no result
    localparam int TAIL_CYCLES  = 8;

    // one directed row: relocation fields plus an optional typed-in result
    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] addend;
        logic [31:0] sym;
        logic [31:0] seg;
        logic [31:0] off;
        logic [31:0] fsz;
        logic [31:0] old;
        logic        typed;
        logic [31:0] want_addr;
        logic [31:0] want_word;
        t_status     want_status;
    } t_row;

    // one queued item for the sender
    typedef struct packed {
        t_reloc  item;
        logic    typed;
        t_patch  want;
        logic    calm;
        logic    drain;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_reloc_code = '0;
    logic [31:0] i_addend = '0;
    logic [31:0] i_sym_addr = '0;
    logic [31:0] i_seg_addr = '0;
    logic [31:0] i_patch_offset = '0;
    logic [31:0] i_seg_file_size = '0;
    logic [31:0] i_old_word = '0;
    logic        o_done;
    logic [31:0] o_patch_address;
    logic [31:0] o_new_word;
    logic [2:0]  o_status;

    t_stim  relocs_to_send [$];
    t_patch pending_patches [$];
    int     mismatches = 0;
    int     items_taken = 0;
    int     stuck_cycles = 0;
    int     status_tally [5] = '{0, 0, 0, 0, 0};
    logic   drained = 1'b0;

    logic [7:0] known_codes [14] = '{
        RC_NONE, RC_ABS32, RC_REL32, RC_THM_CALL, RC_CALL, RC_JUMP24, RC_TARGET1,
        RC_V4BX, RC_TARGET2, RC_PREL31, RC_MOVW, RC_MOVT, RC_THM_MOVW, RC_THM_MOVT
    };

    // directed rows: field extremes, every code, range edges, segment bound edges
    t_row directed_rows [24] = '{
        // none wins over the segment bound
        '{RC_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          1'b1, 32'h0, 32'h0, ST_NOOP},
        // unknown code, all fields at their top, address wraps
        '{RC_UNUSED_TOP, '1, '1, '1, '1, '1, '1,
          1'b1, 32'hffff_fffe, 32'hffff_ffff, ST_UNKNOWN},
        // word fits exactly at the end of the segment
        '{RC_ABS32, 32'h4, 32'h1000, 32'h8000, 32'h0, 32'h4, 32'h0,
          1'b1, 32'h8000, 32'h1004, ST_WRITE},
        // one byte past the end
        '{RC_ABS32, 32'h4, 32'h1000, 32'h8000, 32'h1, 32'h4, 32'hdead_beef,
          1'b1, 32'h8001, 32'hdead_beef, ST_BEYOND},
        // offset plus four must not wrap
        '{RC_ABS32, 32'h0, 32'h0, 32'h0, '1, '1, 32'h1234_5678,
          1'b1, 32'hffff_ffff, 32'h1234_5678, ST_BEYOND},
        // largest offset that still fits
        '{RC_ABS32, '1, '1, '1, 32'hffff_fffb, '1, 32'h0,
          1'b1, 32'hffff_fffa, 32'hffff_fffe, ST_WRITE},
        '{RC_REL32, 32'h10, 32'h2000, 32'h1000, 32'h100, '1, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_TARGET1, '1, 32'h2, 32'h0, 32'h0, 32'h4, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_TARGET2, 32'h0, 32'h0, 32'h0, 32'h8, 32'h100, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        // thumb call at both edges of its reach
        '{RC_THM_CALL, 32'h0, 32'h00ff_ffff, 32'h0, 32'h0, '1, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_THM_CALL, 32'h0, 32'h0100_0000, 32'h0, 32'h0, '1, 32'hf800_f800,
          1'b1, 32'h0, 32'hf800_f800, ST_RANGE},
        '{RC_THM_CALL, 32'h0, 32'hff00_0001, 32'h0, 32'h0, '1, '1,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_THM_CALL, 32'h0, 32'hff00_0000, 32'h0, 32'h0, '1, 32'h0,
          1'b1, 32'h0, 32'h0, ST_RANGE},
        // arm call and jump at both edges of their reach
        '{RC_CALL, 32'h0, 32'h01ff_fffc, 32'h0, 32'h0, '1, 32'heb00_0000,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        // out of range reported ahead of the segment bound
        '{RC_CALL, 32'h0, 32'h0200_0000, 32'h0, 32'h0, 32'h0, 32'heb00_0000,
          1'b1, 32'h0, 32'heb00_0000, ST_RANGE},
        '{RC_JUMP24, 32'h0, 32'hfe00_0001, 32'h0, 32'h0, '1, 32'hea00_0000,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_JUMP24, 32'h0, 32'hfe00_0000, 32'h0, 32'h0, '1, 32'hea00_0000,
          1'b1, 32'h0, 32'hea00_0000, ST_RANGE},
        '{RC_V4BX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h4, '1,
          1'b1, 32'h0, 32'hf1a0_f00f, ST_WRITE},
        // prel31 keeps bit 31 of the old word either way
        '{RC_PREL31, 32'h0, 32'h1234_5678, 32'h0, 32'h0, 32'h4, 32'h8000_0000,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_PREL31, 32'h0, '1, 32'h0, 32'h0, 32'h4, 32'h7fff_ffff,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_MOVW, 32'h5678, 32'h1234_0000, 32'h0, 32'h0, 32'h4, '1,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_MOVT, 32'h5678, 32'h1234_0000, 32'h0, 32'h0, 32'h4, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_THM_MOVW, 32'h0, '1, 32'h0, 32'h0, 32'h4, 32'h0,
          1'b0, 32'h0, 32'h0, ST_WRITE},
        '{RC_THM_MOVT, 32'h0, '1, 32'h0, 32'h0, 32'h4, '1,
          1'b0, 32'h0, 32'h0, ST_WRITE}
    };

    arm_relocation_patcher_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_reloc_code    (i_reloc_code),
        .i_addend        (i_addend),
        .i_sym_addr      (i_sym_addr),
        .i_seg_addr      (i_seg_addr),
        .i_patch_offset  (i_patch_offset),
        .i_seg_file_size (i_seg_file_size),
        .i_old_word      (i_old_word),
        .o_done          (o_done),
        .o_patch_address (o_patch_address),
        .o_new_word      (o_new_word),
        .o_status        (o_status)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // signed branch distance strictly inside +-reach
    function automatic logic in_reach(input logic [31:0] delta, input logic [31:0] reach);
        int signed_gap;
        signed_gap = delta;
        return signed_gap > -int'(reach) && signed_gap < int'(reach);
    endfunction

    // expected patch for one relocation
    function automatic t_patch predict_patch(input t_reloc r);
        t_patch      p;
        logic [31:0] place;
        logic [31:0] sym_plus_addend;
        logic [31:0] pc_rel;
        logic [31:0] word;
        logic [15:0] first_half;
        logic [15:0] second_half;
        logic [15:0] imm;
        logic        sg;
        t_status     st;
        place           = r.seg_addr + r.patch_offset;
        sym_plus_addend = r.sym_addr + r.addend;
        pc_rel          = sym_plus_addend - place;
        first_half      = r.old_word[15:0];
        second_half     = r.old_word[31:16];
        imm             = (r.reloc_code == RC_MOVT || r.reloc_code == RC_THM_MOVT) ?
                          sym_plus_addend[31:16] : sym_plus_addend[15:0];
        sg              = pc_rel[24];
        word            = r.old_word;
        st              = ST_WRITE;
        case (r.reloc_code)
            RC_NONE: st = ST_NOOP;
            RC_V4BX: word = (r.old_word & V4BX_KEEP_MASK) | V4BX_MOV_PC_LR;
            RC_ABS32, RC_TARGET1: word = sym_plus_addend;
            RC_REL32, RC_TARGET2: word = pc_rel;
            RC_THM_CALL: begin
                if (!in_reach(pc_rel, THUMB_REACH)) begin
                    st = ST_RANGE;
                end else begin
                    // second halfword: j1, j2 and imm11; first: sign and imm10
                    word = {second_half[15:14], sg ^ ~pc_rel[23], second_half[12],
                            sg ^ ~pc_rel[22], pc_rel[11:1],
                            first_half[15:11], sg, pc_rel[21:12]};
                end
            end
            RC_CALL, RC_JUMP24: begin
                if (!in_reach(pc_rel, ARM_REACH)) begin
                    st = ST_RANGE;
                end else begin
                    word = {r.old_word[31:24], pc_rel[25:2]};
                end
            end
            RC_PREL31: word = {r.old_word[31], pc_rel[30:0]};
            RC_MOVW, RC_MOVT: word = {r.old_word[31:20], imm[15:12], r.old_word[15:12],
                                      imm[11:0]};
            RC_THM_MOVW, RC_THM_MOVT: word = {second_half[15], imm[10:8], second_half[11:8],
                                              imm[7:0], first_half[15:11], imm[11],
                                              first_half[9:4], imm[15:12]};
            default: st = ST_UNKNOWN;
        endcase
        // four bytes must fit in the segment, compared without wrap
        if (st == ST_WRITE && {1'b0, r.patch_offset} + 33'd4 > {1'b0, r.seg_file_size})
            st = ST_BEYOND;
        if (st != ST_WRITE)
            word = r.old_word;
        p.patch_address = place;
        p.new_word      = word;
        p.status        = st;
        return p;
    endfunction

    // random relocation; branches are mostly aimed near or inside their reach
    function automatic t_reloc random_reloc();
        t_reloc      r;
        logic [31:0] reach;
        logic [31:0] span;
        logic [31:0] d;
        if ($urandom_range(0, 99) < 5)
            r.reloc_code = 8'($urandom_range(0, 255));
        else
            r.reloc_code = known_codes[$urandom_range(0, 13)];
        r.addend   = $urandom;
        r.sym_addr = $urandom;
        r.seg_addr = $urandom;
        r.old_word = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                r.seg_file_size = $urandom;
                r.patch_offset  = $urandom;
            end
            1: begin
                // straddle the end of the segment
                r.seg_file_size = $urandom;
                r.patch_offset  = r.seg_file_size - $urandom_range(0, 7);
            end
            default: begin
                r.seg_file_size = $urandom_range(4, 32'hffff_ffff);
                r.patch_offset  = $urandom_range(0, r.seg_file_size - 4);
            end
        endcase
        if ((r.reloc_code == RC_THM_CALL || r.reloc_code == RC_CALL ||
             r.reloc_code == RC_JUMP24) && $urandom_range(0, 4) != 0) begin
            reach = (r.reloc_code == RC_THM_CALL) ? THUMB_REACH : ARM_REACH;
            if ($urandom_range(0, 3) == 0) begin
                d = reach - 32'd1 + $urandom_range(0, 2);
            end else begin
                span = (reach << 1) - 32'd1;
                d = $urandom & span;
                if ((d & reach) != 0)
                    d = d | ~span;
            end
            if ($urandom_range(0, 1) == 1)
                d = -d;
            r.addend = r.seg_addr + r.patch_offset + d - r.sym_addr;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want_v, got_v);
    endtask

    // sender, result checker and activity count in one process so queue
    // updates at an edge never race each other
    always @(posedge i_clk) begin : handshake
        t_patch want;
        logic   took;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;

            // result side first: it belongs to the oldest pending item
            if (o_done) begin
                if (pending_patches.size() == 0) begin
                    note_mismatch("unexpected result address", '0, o_patch_address);
                end else begin
                    want = pending_patches.pop_front();
                    if (o_patch_address !== want.patch_address)
                        note_mismatch("patch_address", want.patch_address, o_patch_address);
                    if (o_new_word !== want.new_word)
                        note_mismatch("new_word", want.new_word, o_new_word);
                    if (o_status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_status));
                end
            end

            // item taken at this edge: queue its expected patch
            if (took) begin
                want = relocs_to_send[0].typed ? relocs_to_send[0].want :
                       predict_patch(relocs_to_send[0].item);
                pending_patches.push_back(want);
                status_tally[want.status]++;
                void'(relocs_to_send.pop_front());
                items_taken++;
            end

            // choose what the ports carry next, unless an item is being held
            if (took || !start) begin
                if (relocs_to_send.size() == 0 ||
                    (relocs_to_send[0].drain && pending_patches.size() != 0) ||
                    (!relocs_to_send[0].calm && $urandom_range(0, 99) < 29)) begin
                    start <= 1'b0;
                end else begin
                    start           <= 1'b1;
                    i_reloc_code    <= relocs_to_send[0].item.reloc_code;
                    i_addend        <= relocs_to_send[0].item.addend;
                    i_sym_addr      <= relocs_to_send[0].item.sym_addr;
                    i_seg_addr      <= relocs_to_send[0].item.seg_addr;
                    i_patch_offset  <= relocs_to_send[0].item.patch_offset;
                    i_seg_file_size <= relocs_to_send[0].item.seg_file_size;
                    i_old_word      <= relocs_to_send[0].item.old_word;
                end
            end

            if (took || o_done)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;

            drained <= relocs_to_send.size() == 0 && pending_patches.size() == 0;
        end
    end

    // watchdog: no item and no result for too long
    always @(negedge i_clk) begin
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("watchdog: no activity for %0d cycles, %0d results outstanding",
                     stuck_cycles, pending_patches.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : run
        t_stim s;

        // directed rows first, then the random relocations
        foreach (directed_rows[n]) begin
            s.item.reloc_code    = directed_rows[n].code;
            s.item.addend        = directed_rows[n].addend;
            s.item.sym_addr      = directed_rows[n].sym;
            s.item.seg_addr      = directed_rows[n].seg;
            s.item.patch_offset  = directed_rows[n].off;
            s.item.seg_file_size = directed_rows[n].fsz;
            s.item.old_word      = directed_rows[n].old;
            s.typed              = directed_rows[n].typed;
            s.want.patch_address = directed_rows[n].want_addr;
            s.want.new_word      = directed_rows[n].want_word;
            s.want.status        = directed_rows[n].want_status;
            s.calm               = 1'b0;
            s.drain              = 1'b0;
            relocs_to_send.push_back(s);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            s.item  = random_reloc();
            s.typed = 1'b0;
            s.want  = '0;
            s.calm  = n >= CALM_FIRST && n < CALM_LAST;
            // empty pipe before the random part and once in its middle
            s.drain = n == 0 || n == DRAIN_AT;
            relocs_to_send.push_back(s);
        end

        // synchronous reset asserted from time zero, then released for good
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every item sent and every result in, then a short tail for strays
        do @(posedge i_clk); while (!drained);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d relocation items: %0d directed, %0d random",
                 items_taken, $size(directed_rows), RANDOM_ITEMS);
        $display("outcomes: write %0d, no-op %0d, unknown %0d, out of range %0d, beyond %0d",
                 status_tally[ST_WRITE], status_tally[ST_NOOP], status_tally[ST_UNKNOWN],
                 status_tally[ST_RANGE], status_tally[ST_BEYOND]);
        if (mismatches == 0 && pending_patches.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/arp_pkg.sv
src/arp_patch_calc.sv
src/arm_relocation_patcher_top.sv
src/arp_checker.sv
verif/tb.sv
